FILE: rtl/core/ghp_pkg.sv
package ghp_pkg;

	// Default pool size; the top level hands its parameter down from here.
	localparam int SLOT_COUNT_DEF = 1024;

	// Fixed field widths of the request and response channels.
	localparam int ACTION_W   = 1;
	localparam int FIDX_W     = 16;
	localparam int GEN_W      = 32;
	localparam int PAY_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int HIDX_W     = 10;
	localparam int LIVE_OUT_W = 11;

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STALE     = 3'd4;

	// Generation held by a slot that has never been written.
	localparam logic [GEN_W-1:0] GEN_RESET = 32'd1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HIDX_W-1:0]   handle_index;
		logic [GEN_W-1:0]    handle_generation;
	} result_t;

endpackage

FILE: rtl/core/ghp_ram.sv
module ghp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = ghp_pkg::SLOT_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/ghp_slot_update.sv
module ghp_slot_update #(
	parameter int SLOT_COUNT = ghp_pkg::SLOT_COUNT_DEF
) (
	input  logic [ghp_pkg::ACTION_W-1:0]               action,
	input  logic [ghp_pkg::FIDX_W-1:0]                 free_index,
	input  logic [ghp_pkg::GEN_W-1:0]                  free_generation,
	input  logic [ghp_pkg::GEN_W+$clog2(SLOT_COUNT+1):0] ram_entry,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]            head,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]            fill,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]            live_total,
	output ghp_pkg::result_t                           result,
	output logic [$clog2(SLOT_COUNT+1)-1:0]            head_next,
	output logic [$clog2(SLOT_COUNT+1)-1:0]            fill_next,
	output logic [$clog2(SLOT_COUNT+1)-1:0]            live_next,
	output logic                                       wr_en,
	output logic [$clog2(SLOT_COUNT)-1:0]              wr_addr,
	output logic [ghp_pkg::GEN_W+$clog2(SLOT_COUNT+1):0] wr_entry
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int LINK_W = $clog2(SLOT_COUNT + 1);
	localparam int GEN_W  = ghp_pkg::GEN_W;
	localparam int WIDE_W = ghp_pkg::FIDX_W + 1;

	logic [IDX_W-1:0]   idx;
	logic [LINK_W-1:0]  idx_link;
	logic               virgin;
	logic               ent_live;
	logic [GEN_W-1:0]   ent_gen;
	logic [LINK_W-1:0]  ent_next;
	logic [WIDE_W-1:0]  fidx_wide;
	logic [WIDE_W-1:0]  fill_wide;
	logic [31:0]        idx_ext;

	assign fidx_wide = {1'b0, free_index};
	assign fill_wide = WIDE_W'(fill);

	always_comb begin
		if (action == ghp_pkg::ACT_ALLOC) begin
			idx    = head[IDX_W-1:0];
			virgin = (head >= fill);
		end else begin
			idx    = free_index[IDX_W-1:0];
			virgin = (fidx_wide >= fill_wide);
		end
	end

	assign idx_link = LINK_W'(idx);
	assign idx_ext  = 32'(idx);

	// Slots at or above the fill mark have never been written and still hold
	// their reset contents: generation one, dead, linked to the next slot.
	always_comb begin
		if (virgin) begin
			ent_live = 1'b0;
			ent_gen  = ghp_pkg::GEN_RESET;
			ent_next = idx_link + LINK_W'(1);
		end else begin
			ent_live = ram_entry[GEN_W+LINK_W];
			ent_gen  = ram_entry[GEN_W+LINK_W-1:LINK_W];
			ent_next = ram_entry[LINK_W-1:0];
		end
	end

	always_comb begin
		result.status            = ghp_pkg::ST_FULL;
		result.handle_index      = '0;
		result.handle_generation = '0;
		head_next = head;
		fill_next = fill;
		live_next = live_total;
		wr_en     = 1'b0;
		wr_addr   = idx;
		wr_entry  = {ent_live, ent_gen, ent_next};
		if (action == ghp_pkg::ACT_ALLOC) begin
			if (head < LINK_W'(SLOT_COUNT)) begin
				result.status            = ghp_pkg::ST_ALLOCATED;
				result.handle_index      = idx_ext[ghp_pkg::HIDX_W-1:0];
				result.handle_generation = ent_gen;
				head_next = ent_next;
				if (virgin) begin
					fill_next = fill + LINK_W'(1);
				end
				live_next = live_total + LINK_W'(1);
				wr_en     = 1'b1;
				wr_entry  = {1'b1, ent_gen, ent_next};
			end
		end else begin
			if (fidx_wide >= WIDE_W'(SLOT_COUNT)) begin
				result.status = ghp_pkg::ST_RANGE;
			end else if (!ent_live || ent_gen != free_generation) begin
				result.status = ghp_pkg::ST_STALE;
			end else begin
				result.status = ghp_pkg::ST_FREED;
				head_next = idx_link;
				if (live_total != '0) begin
					live_next = live_total - LINK_W'(1);
				end
				wr_en    = 1'b1;
				wr_entry = {1'b0, ent_gen + GEN_W'(1), head};
			end
		end
	end

endmodule

FILE: rtl/core/generational_handle_pool_top.sv
// Generational handle pool: a fixed pool of SLOT_COUNT slots that hands out
// handles made of a slot index and a 32-bit generation.
// Requests arrive on the req channel (req_valid, req_stall); action selects
// an allocate, which pops the free list and stores payload_x/payload_y, or a
// free of the handle given by free_index and free_generation. Every request
// produces exactly one response on the rsp channel (rsp_valid, rsp_stall)
// with a status, the handle on a successful allocate, and the live count.
// A transfer happens on each channel at a rising edge where valid is high
// and stall is low. A request passes the input stage, then the output
// register. While the receiver does not stall, one request can be taken
// every cycle; the single slot-store read per request is issued as the
// request is taken, and the store is written back as its response is formed.
// When the receiver stalls, the finished response waits in the output
// register while one more request is taken into the input stage; the input
// then stalls until the output drains.
// After reset the free list holds every slot in index order, all
// generations are one and nothing is live. No clearing pass is needed: a fill
// mark tells which slots have never been written, so requests are taken from
// the first cycle after reset.
module generational_handle_pool_top #(
	parameter int SLOT_COUNT = ghp_pkg::SLOT_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [ghp_pkg::ACTION_W-1:0]       action,
	input  logic [ghp_pkg::FIDX_W-1:0]         free_index,
	input  logic [ghp_pkg::GEN_W-1:0]          free_generation,
	input  logic [ghp_pkg::PAY_W-1:0]          payload_x,
	input  logic [ghp_pkg::PAY_W-1:0]          payload_y,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ghp_pkg::STATUS_W-1:0]       status,
	output logic [ghp_pkg::HIDX_W-1:0]         handle_index,
	output logic [ghp_pkg::GEN_W-1:0]          handle_generation,
	output logic [ghp_pkg::LIVE_OUT_W-1:0]     live_count
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int LINK_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W  = 1 + ghp_pkg::GEN_W + LINK_W;

	// Input stage.
	logic                          v_s1;
	logic [ghp_pkg::ACTION_W-1:0]  action_s1;
	logic [ghp_pkg::FIDX_W-1:0]    free_index_s1;
	logic [ghp_pkg::GEN_W-1:0]     free_generation_s1;
	logic [ghp_pkg::PAY_W-1:0]     payload_x_s1;
	logic [ghp_pkg::PAY_W-1:0]     payload_y_s1;
	logic                          byp_hit_s1;
	logic [ENT_W-1:0]              byp_entry_s1;

	// Pool state.
	logic [LINK_W-1:0]             head_q;
	logic [LINK_W-1:0]             fill_q;
	logic [LINK_W-1:0]             live_q;

	// Output register.
	logic                          rsp_valid_q;
	ghp_pkg::result_t              res_q;
	logic [LINK_W-1:0]             live_out_q;

	logic                          req_take;
	logic                          s1_move;
	logic                          wr_fire;
	logic [ENT_W-1:0]              rd_entry;
	logic [ENT_W-1:0]              cur_entry;
	logic [IDX_W-1:0]              rd_addr;
	logic [LINK_W-1:0]             head_sel;
	ghp_pkg::result_t              upd_result;
	logic [LINK_W-1:0]             upd_head;
	logic [LINK_W-1:0]             upd_fill;
	logic [LINK_W-1:0]             upd_live;
	logic                          upd_wr_en;
	logic [IDX_W-1:0]              upd_wr_addr;
	logic [ENT_W-1:0]              upd_wr_entry;
	logic [31:0]                   live_ext;

	// The item in the input stage commits when the output register is free
	// or is being drained in the same cycle.
	assign s1_move   = v_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = v_s1 && !s1_move;
	assign req_take  = req_valid && !req_stall;
	assign wr_fire   = s1_move && upd_wr_en;

	// The next allocate reads at the head that the committing item leaves.
	assign head_sel = s1_move ? upd_head : head_q;

	always_comb begin
		if (action == ghp_pkg::ACT_ALLOC) begin
			rd_addr = head_sel[IDX_W-1:0];
		end else begin
			rd_addr = free_index[IDX_W-1:0];
		end
	end

	// A read issued in the same cycle as a write to that slot sees old data,
	// so the written entry is captured alongside and used instead.
	assign cur_entry = byp_hit_s1 ? byp_entry_s1 : rd_entry;

	ghp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_fire),
		.wr_addr (upd_wr_addr),
		.wr_data (upd_wr_entry),
		.rd_en   (req_take),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	// Payload store: written on every successful allocate.
	ghp_ram #(
		.WIDTH(2 * ghp_pkg::PAY_W),
		.DEPTH(SLOT_COUNT)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (wr_fire && action_s1 == ghp_pkg::ACT_ALLOC),
		.wr_addr (upd_wr_addr),
		.wr_data ({payload_y_s1, payload_x_s1}),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	ghp_slot_update #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_update (
		.action          (action_s1),
		.free_index      (free_index_s1),
		.free_generation (free_generation_s1),
		.ram_entry       (cur_entry),
		.head            (head_q),
		.fill            (fill_q),
		.live_total      (live_q),
		.result          (upd_result),
		.head_next       (upd_head),
		.fill_next       (upd_fill),
		.live_next       (upd_live),
		.wr_en           (upd_wr_en),
		.wr_addr         (upd_wr_addr),
		.wr_entry        (upd_wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			if (req_take) begin
				v_s1       <= 1'b1;
				byp_hit_s1 <= wr_fire && (upd_wr_addr == rd_addr);
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			action_s1          <= action;
			free_index_s1      <= free_index;
			free_generation_s1 <= free_generation;
			payload_x_s1       <= payload_x;
			payload_y_s1       <= payload_y;
			byp_entry_s1       <= upd_wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			live_q <= '0;
		end else if (s1_move) begin
			head_q <= upd_head;
			fill_q <= upd_fill;
			live_q <= upd_live;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_q      <= upd_result;
			live_out_q <= upd_live;
		end
	end

	assign live_ext = 32'(live_out_q);

	assign rsp_valid         = rsp_valid_q;
	assign status            = res_q.status;
	assign handle_index      = res_q.handle_index;
	assign handle_generation = res_q.handle_generation;
	assign live_count        = live_ext[ghp_pkg::LIVE_OUT_W-1:0];

endmodule

FILE: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ghp_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;

	// One response as the pool should produce it.
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [HIDX_W-1:0]     index;
		logic [GEN_W-1:0]      generation;
		logic [LIVE_OUT_W-1:0] live;
	} pool_answer_t;

	// Every block input starts at a known value.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic [ACTION_W-1:0]   action = ACT_ALLOC;
	logic [FIDX_W-1:0]     free_index = '0;
	logic [GEN_W-1:0]      free_generation = '0;
	logic [PAY_W-1:0]      payload_x = '0;
	logic [PAY_W-1:0]      payload_y = '0;
	logic                  rsp_stall = 1'b0;
	logic                  req_stall;
	logic                  rsp_valid;
	logic [STATUS_W-1:0]   status;
	logic [HIDX_W-1:0]     handle_index;
	logic [GEN_W-1:0]      handle_generation;
	logic [LIVE_OUT_W-1:0] live_count;

	// Shadow copy of the pool. The payload store is never read back, so it
	// has no copy here.
	logic [GEN_W-1:0]      pool_gen [SLOTS];
	bit                    pool_live [SLOTS];
	logic [10:0]           pool_link [SLOTS];
	logic [10:0]           pool_head;
	logic [10:0]           pool_live_total;

	// Answers predicted for accepted requests, oldest first.
	pool_answer_t          awaited_answers [$];

	int                    mismatch_count = 0;
	int                    requests_sent = 0;
	int                    answers_checked = 0;
	int                    stalled_input_cycles = 0;
	int                    answer_tally [5] = '{0, 0, 0, 0, 0};

	// Idling controls; the last part of the run clears both.
	bit                    sender_idles = 1'b1;
	bit                    receiver_idles = 1'b1;
	bit                    hold_trigger = 1'b0;
	int                    hold_left = 0;
	int                    gap_left = 0;

	generational_handle_pool_top #(
		.SLOT_COUNT(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.free_index(free_index),
		.free_generation(free_generation),
		.payload_x(payload_x),
		.payload_y(payload_y),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.handle_index(handle_index),
		.handle_generation(handle_generation),
		.live_count(live_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Puts the shadow pool into its reset state: generation one everywhere,
	// nothing live, and every slot chained to the next in index order. The
	// last link holds the empty marker, which equals the slot count.
	task automatic clear_shadow_pool();
		for (int s = 0; s < SLOTS; s++) begin
			pool_gen[s] = GEN_RESET;
			pool_live[s] = 1'b0;
			pool_link[s] = 11'(s + 1);
		end
		pool_head = '0;
		pool_live_total = '0;
	endtask

	// Applies one accepted request to the shadow pool and returns the answer
	// the block owes for it.
	function automatic pool_answer_t apply_request(logic [ACTION_W-1:0] act,
			logic [FIDX_W-1:0] fidx, logic [GEN_W-1:0] fgen);
		pool_answer_t a;
		int slot;
		a = '0;
		if (act == ACT_ALLOC) begin
			// A head at or past the end of the pool means the list is empty.
			if (pool_head >= SLOTS) begin
				a.status = ST_FULL;
			end else begin
				slot = int'(pool_head);
				pool_head = pool_link[slot];
				pool_live[slot] = 1'b1;
				pool_live_total = pool_live_total + 1'b1;
				a.status = ST_ALLOCATED;
				a.index = HIDX_W'(slot);
				a.generation = pool_gen[slot];
			end
		end else if (fidx >= SLOTS) begin
			a.status = ST_RANGE;
		end else if (!pool_live[fidx] || pool_gen[fidx] != fgen) begin
			// Dead slot or wrong generation: the handle is stale.
			a.status = ST_STALE;
		end else begin
			// The freed slot goes to the front of the list, and its
			// generation moves on with a 32-bit wrap.
			pool_live[fidx] = 1'b0;
			pool_gen[fidx] = pool_gen[fidx] + 1'b1;
			pool_link[fidx] = pool_head;
			pool_head = 11'(fidx);
			if (pool_live_total != 0)
				pool_live_total = pool_live_total - 1'b1;
			a.status = ST_FREED;
		end
		a.live = pool_live_total;
		return a;
	endfunction

	// Offers one request and holds it until the block takes it. The
	// prediction is made in this process right at the accepting edge, so the
	// stimulus that follows always sees the shadow pool up to date. Valid
	// stays high into the next request unless an idle burst follows.
	task automatic send_request(logic [ACTION_W-1:0] act, logic [FIDX_W-1:0] fidx,
			logic [GEN_W-1:0] fgen, logic [PAY_W-1:0] px, logic [PAY_W-1:0] py);
		req_valid <= 1'b1;
		action <= act;
		free_index <= fidx;
		free_generation <= fgen;
		payload_x <= px;
		payload_y <= py;
		do @(posedge clk); while (req_stall);
		awaited_answers.push_back(apply_request(act, fidx, fgen));
		requests_sent++;
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_alloc();
		send_request(ACT_ALLOC, FIDX_W'($urandom), $urandom, $urandom, $urandom);
	endtask

	// Returns a random slot that is live (or dead, as asked), or -1 if there
	// is none.
	function automatic int pick_slot(bit want_live);
		int start;
		int s;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			s = (start + k) % SLOTS;
			if (pool_live[s] == want_live)
				return s;
		end
		return -1;
	endfunction

	// Frees a handle that is really live; with nothing live it allocates.
	task automatic free_live_handle();
		int s;
		s = pick_slot(1'b1);
		if (s < 0)
			send_alloc();
		else
			send_request(ACT_FREE, FIDX_W'(s), pool_gen[s], $urandom, $urandom);
	endtask

	// A free with a random index and generation. Most of the index space is
	// out of range; an in-range index almost never matches.
	task automatic send_noise_free();
		logic [FIDX_W-1:0] fidx;
		case ($urandom_range(0, 2))
			0: fidx = FIDX_W'($urandom);
			1: fidx = FIDX_W'($urandom_range(SLOTS, 65535));
			default: fidx = FIDX_W'($urandom_range(0, SLOTS - 1));
		endcase
		send_request(ACT_FREE, fidx, $urandom, $urandom, $urandom);
	endtask

	// A free of a handle that was once good or nearly good: a live slot with
	// one generation bit flipped, or a dead slot with its current or its
	// previous generation.
	task automatic send_stale_free();
		int s;
		case ($urandom_range(0, 2))
			0: begin
				s = pick_slot(1'b1);
				if (s >= 0)
					send_request(ACT_FREE, FIDX_W'(s),
						pool_gen[s] ^ (32'd1 << $urandom_range(0, 31)), $urandom, $urandom);
			end
			1: begin
				s = pick_slot(1'b0);
				if (s >= 0)
					send_request(ACT_FREE, FIDX_W'(s), pool_gen[s], $urandom, $urandom);
			end
			default: begin
				s = pick_slot(1'b0);
				if (s >= 0)
					send_request(ACT_FREE, FIDX_W'(s), pool_gen[s] - 1'b1, $urandom, $urandom);
			end
		endcase
		if (s < 0)
			send_noise_free();
	endtask

	// Short hand-picked sequence right after reset. Expected answers come
	// from the shadow pool, so only the shape of the sequence matters here:
	// payload extremes, both range errors, a dead slot, wrong generations at
	// both extremes, a double free, and reuse of freed slots in last-in
	// first-out order with their new generation.
	task automatic test_directed_cases();
		send_request(ACT_ALLOC, '0, '0, '0, '0);
		send_request(ACT_ALLOC, '1, '1, '1, '1);
		send_alloc();
		send_request(ACT_FREE, FIDX_W'(SLOTS), 32'd1, $urandom, $urandom);
		send_request(ACT_FREE, '1, '1, '0, '0);
		send_request(ACT_FREE, FIDX_W'(SLOTS - 1), GEN_RESET, '1, '1);
		send_request(ACT_FREE, 16'd0, '0, $urandom, $urandom);
		send_request(ACT_FREE, 16'd0, '1, $urandom, $urandom);
		send_request(ACT_FREE, 16'd1, GEN_RESET, $urandom, $urandom);
		send_request(ACT_FREE, 16'd1, GEN_RESET, $urandom, $urandom);
		send_request(ACT_FREE, 16'd1, GEN_RESET + 1'b1, $urandom, $urandom);
		send_alloc();
		send_request(ACT_FREE, 16'd0, GEN_RESET, $urandom, $urandom);
		send_request(ACT_FREE, 16'd2, GEN_RESET, $urandom, $urandom);
		send_alloc();
		send_alloc();
		send_alloc();
	endtask

	// Allocates until the pool is empty of free slots, with some bad frees
	// mixed in. The receiver holds off for a long stretch at the start so the
	// block backs up and stalls its input while requests keep coming. Once
	// full, allocates must report a full pool until a slot is freed again.
	task automatic test_fill_to_full();
		hold_trigger = 1'b1;
		while (pool_head < SLOTS) begin
			if ($urandom_range(0, 39) == 0)
				send_noise_free();
			else
				send_alloc();
		end
		repeat (4) send_alloc();
		free_live_handle();
		send_alloc();
		send_alloc();
		send_stale_free();
	endtask

	// Mostly well-formed traffic: frees of live handles and allocates, with
	// stale and random frees as the rest.
	task automatic test_random_churn(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 48)
				free_live_handle();
			else if (pick < 85)
				send_alloc();
			else if (pick < 95)
				send_stale_free();
			else
				send_noise_free();
		end
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_steady_stream();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		test_random_churn(40);
	endtask

	// Receiver. A long hold is requested by the stimulus and counted here;
	// otherwise the stall comes in random bursts.
	always @(posedge clk) begin
		if (hold_trigger) begin
			hold_left = 90;
			hold_trigger = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			rsp_stall <= 1'b1;
		end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
			gap_left = $urandom_range(1, 10) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
				$time, name, want, want, got, got);
			mismatch_count++;
		end
	endtask

	// Checker: every response transfer is compared with the oldest answer.
	always @(posedge clk) begin
		pool_answer_t want;
		if (arst_n && req_valid && req_stall)
			stalled_input_cycles++;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_answers.size() == 0) begin
				$display("%0t: response with no request pending, expected none, actual status %0d",
					$time, status);
				mismatch_count++;
			end else begin
				want = awaited_answers.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("handle_index", 32'(want.index), 32'(handle_index));
				report_field("handle_generation", want.generation, handle_generation);
				report_field("live_count", 32'(want.live), 32'(live_count));
				if (want.status <= ST_STALE)
					answer_tally[want.status]++;
				answers_checked++;
			end
		end
	end

	initial begin
		clear_shadow_pool();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fill_to_full();
		test_random_churn(25);
		test_steady_stream();

		req_valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		// Keep the clock running so a stray extra response would be seen.
		repeat (8) @(posedge clk);
		if (awaited_answers.size() != 0) begin
			$display("%0t: %0d answers never arrived", $time, awaited_answers.size());
			mismatch_count++;
		end

		$display("covered %0d requests, %0d responses: %0d allocated, %0d full, %0d freed",
			requests_sent, answers_checked, answer_tally[ST_ALLOCATED],
			answer_tally[ST_FULL], answer_tally[ST_FREED]);
		$display("  %0d out of range, %0d stale; input held back for %0d cycles",
			answer_tally[ST_RANGE], answer_tally[ST_STALE], stalled_input_cycles);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ghp_pkg.sv
rtl/core/ghp_ram.sv
rtl/core/ghp_slot_update.sv
rtl/core/generational_handle_pool_top.sv
test/tb.sv
